// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Delayed implication, off while reset is held.
`define ASSERT_TWO(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

// ----- src/swm_pkg.sv -----
// Shared types and constants of the running median filter.
package swm_pkg;

    localparam int SAMPLE_W = 16;

    // Smallest stored sample; zero marks an empty cell.
    localparam logic [SAMPLE_W-1:0] MIN_SAMPLE = 16'd1;
    localparam logic [SAMPLE_W-1:0] STOPPER    = 16'd0;

    // Flags handed from one cell to the next one down the chain.
    typedef struct packed {
        logic del_le;  // evicted cell sits at or above this one
        logic lt;      // post-eviction value here is below the new sample
    } t_flag;

endpackage

// ----- src/swm_cell.sv -----
// One cell of the sorted chain: value, age and local insert/evict rule.
module swm_cell #(
    parameter int AW     = 3,
    parameter int OLDEST = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [swm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [swm_pkg::SAMPLE_W-1:0]   i_up_val,
    input  logic [AW-1:0]                  i_up_age,
    input  logic [swm_pkg::SAMPLE_W-1:0]   i_dn_val,
    input  logic [AW-1:0]                  i_dn_age,
    input  swm_pkg::t_flag                 i_up,
    output swm_pkg::t_flag                 o_flag,
    output logic [swm_pkg::SAMPLE_W-1:0]   o_val,
    output logic [AW-1:0]                  o_age
);
    import swm_pkg::*;

    logic [SAMPLE_W-1:0] r_val, n_val;
    logic [AW-1:0]       r_age, n_age;
    logic                hit;
    logic [SAMPLE_W-1:0] w_val, w_up_val;
    logic [AW-1:0]       w_age, w_up_age;

    // Oldest live sample drops out of the chain.
    assign hit    = (r_val != STOPPER) && (r_age == AW'(OLDEST));
    assign o_flag.del_le = i_up.del_le | hit;

    // Chain contents once the oldest sample has been removed.
    assign w_val    = o_flag.del_le ? i_dn_val : r_val;
    assign w_age    = o_flag.del_le ? i_dn_age : r_age;
    assign w_up_val = i_up.del_le ? r_val : i_up_val;
    assign w_up_age = i_up.del_le ? r_age : i_up_age;

    assign o_flag.lt = (w_val < i_sample);

    always_comb begin
        if (o_flag.lt && i_up.lt) begin
            n_val = w_up_val;
            n_age = w_up_age + 1'b1;
        end else if (o_flag.lt) begin
            n_val = i_sample;
            n_age = '0;
        end else begin
            n_val = w_val;
            n_age = w_age + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= STOPPER;
        end else if (i_load) begin
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_age <= n_age;
        end
    end

    assign o_val = r_val;
    assign o_age = r_age;

endmodule

// ----- src/sliding_window_median.sv -----
// Top level of the running median filter over the last WINDOW_SIZE samples.
// An accepted request is first written into the cell chain; its median then goes to the output register.
// Throughput: one request per cycle while o_stall is low; the sorted cell chain evicts and inserts in the same cycle.
// Output stalls hold the result register; input is stalled only while a result waits.
// Reset (synchronous, active low) empties the chain and clears fill count and valids.
module sliding_window_median #(
    parameter int WINDOW_SIZE = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [swm_pkg::SAMPLE_W-1:0]  o_median
);
    import swm_pkg::*;

    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);

    logic                accept;
    logic                load;
    logic [SAMPLE_W-1:0] sample_fix;

    logic [SAMPLE_W-1:0] cell_val [WINDOW_SIZE];
    logic [AW-1:0]       cell_age [WINDOW_SIZE];
    t_flag               cell_flg [WINDOW_SIZE];

    logic [CW-1:0]       r_fill, n_fill;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_median;
    logic [CW-1:0]       mid;
    logic [SAMPLE_W-1:0] pick;

    // Handshake: a request is taken whenever no finished result is stuck
    // waiting for the output register.
    assign load    = r_pend && (!r_out_valid || !i_stall);
    assign o_stall = r_pend && !load;
    assign accept  = i_valid && !o_stall;

    // Zero is the empty-cell marker, so map it to the smallest sample.
    assign sample_fix = (i_sample == STOPPER) ? MIN_SAMPLE : i_sample;

    // Sorted chain, largest value in cell 0, empty cells (zero) at the bottom.
    // Each cell looks only at its neighbours, at the flags from above and at the new sample.
    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        logic [SAMPLE_W-1:0] up_val, dn_val;
        logic [AW-1:0]       up_age, dn_age;
        t_flag               up_flg;

        if (g == 0) begin : g_top
            assign up_val = STOPPER;
            assign up_age = '0;
            assign up_flg = '0;
        end else begin : g_mid
            assign up_val = cell_val[g-1];
            assign up_age = cell_age[g-1];
            assign up_flg = cell_flg[g-1];
        end

        if (g == WINDOW_SIZE - 1) begin : g_bot
            assign dn_val = STOPPER;
            assign dn_age = '0;
        end else begin : g_nxt
            assign dn_val = cell_val[g+1];
            assign dn_age = cell_age[g+1];
        end

        swm_cell #(
            .AW     (AW),
            .OLDEST (WINDOW_SIZE - 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (accept),
            .i_sample (sample_fix),
            .i_up_val (up_val),
            .i_up_age (up_age),
            .i_dn_val (dn_val),
            .i_dn_age (dn_age),
            .i_up     (up_flg),
            .o_flag   (cell_flg[g]),
            .o_val    (cell_val[g]),
            .o_age    (cell_age[g])
        );
    end

    // Fill count saturates at the window length.
    always_comb begin
        n_fill = r_fill;
        if (accept && (r_fill != CW'(WINDOW_SIZE))) begin
            n_fill = r_fill + 1'b1;
        end
    end

    // Lower median of k samples sits at index floor(k/2) in descending order.
    assign mid = r_fill >> 1;

    always_comb begin
        pick = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            if (CW'(i) == mid) begin
                pick = pick | cell_val[i];
            end
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (accept) begin
            n_pend = 1'b1;
        end else if (load) begin
            n_pend = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result while downstream stalls.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_median <= pick;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_median = r_median;

endmodule

// ----- src/swm_checker.sv -----
// Port-level checker for the running median filter, bound to the top level.
`include "assert_macros.svh"

module swm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [swm_pkg::SAMPLE_W-1:0]  i_sample,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [swm_pkg::SAMPLE_W-1:0]  o_median
);
    import swm_pkg::*;

    logic in_acc;

    assign in_acc = i_valid && !o_stall;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_median))
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_sample))
    `ASSERT_IMPL(a_never_zero, i_clk, i_rst_n, o_valid, o_median != STOPPER)
    `ASSERT_TWO(a_result_due, i_clk, i_rst_n, in_acc, o_valid)

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
